[rtl/nmtd_pkg.sv]
package nmtd_pkg;

  localparam int TEXEL_W = 24;
  localparam int COMP_W  = 16;

  // Magnitude of a decoded component scaled to the common denominator 127*255.
  localparam int MAG_W = 15;
  localparam int SQ_W  = 2 * MAG_W;
  // Sum of three squares.
  localparam int SUM_W = SQ_W + 2;
  // Rounded magnitude of one output component, 0 to 16384.
  localparam int N_W   = 15;
  localparam int NSTEP = N_W;
  // The target (32768*|C|)^2 is the square shifted up by 30 bits.
  localparam int TGT_SHIFT = 30;
  // Remainder register, running product m*S register and the work width of a step.
  localparam int REM_W  = SQ_W + TGT_SHIFT + 2;
  localparam int PROD_W = SUM_W + N_W + 2;
  localparam int WORK_W = REM_W + 3;

  localparam int NCOMP  = 3;
  localparam int COMP_X = 0;
  localparam int COMP_Y = 1;
  localparam int COMP_Z = 2;

  // State of the digit-by-digit search for one component.
  typedef struct packed {
    logic signed [REM_W-1:0]  rem;
    logic signed [PROD_W-1:0] prod;
    logic [N_W-1:0]           n;
  } nmtd_root_t;

endpackage

[rtl/nmtd_texel_if.sv]
interface nmtd_texel_if;
  import nmtd_pkg::*;

  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] texel;

  modport source (output valid, output texel, input ready);
  modport sink (input valid, input texel, output ready);
endinterface

[rtl/nmtd_normal_if.sv]
interface nmtd_normal_if;
  import nmtd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] normal_x;
  logic signed [COMP_W-1:0] normal_y;
  logic signed [COMP_W-1:0] normal_z;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink (input valid, input normal_x, input normal_y, input normal_z,
                output ready);
endinterface

[rtl/nmtd_cfg_if.sv]
interface nmtd_cfg_if;
  logic valid;
  logic ready;
  logic green_up;

  modport source (output valid, output green_up, input ready);
  modport sink (input valid, input green_up, output ready);
endinterface

[rtl/normal_map_texel_decode.sv]
// Channel   Modport  Payload                          Transfer
// cfg       sink     green_up                         valid && ready
// texels    sink     texel[23:0]                      valid && ready
// normals   source   normal_x, normal_y, normal_z     valid && ready
//
// One texel is taken every cycle while the output register is not stalled. Each
// rounded component is found by the 15-stage digit pipeline, one result bit per
// stage, behind decode, square and sum stages.
// Reset clears the valid bits and green_up; the pipeline holds as a whole
// while a result waits at the output register.
module normal_map_texel_decode (
  input logic           clk,
  input logic           rst,
  nmtd_cfg_if.sink      cfg,
  nmtd_texel_if.sink    texels,
  nmtd_normal_if.source normals
);
  import nmtd_pkg::*;

  logic green_up;
  logic adv;

  // Decode stage.
  logic [7:0]       red, green, blue;
  logic [6:0]       xm, ym;
  logic [7:0]       zm;
  logic [MAG_W-1:0] mag_in [NCOMP];
  logic [NCOMP-1:0] neg_in;

  logic             dec_v;
  logic [MAG_W-1:0] dec_mag [NCOMP];
  logic [NCOMP-1:0] dec_neg;

  // Square stage.
  logic             sq_v;
  logic [SQ_W-1:0]  sq_val [NCOMP];
  logic [NCOMP-1:0] sq_neg;

  // Sum stage.
  logic             sum_v;
  logic [SQ_W-1:0]  sum_sq [NCOMP];
  logic [NCOMP-1:0] sum_neg;
  logic [SUM_W-1:0] sum_s;

  // Search stages: index 0 is the start state, index j+1 follows digit j.
  logic [NSTEP:0]   pipe_v;
  logic [SUM_W-1:0] pipe_s [NSTEP+1];
  logic [NCOMP-1:0] pipe_neg [NSTEP+1];
  nmtd_root_t       root [NSTEP+1][NCOMP];
  nmtd_root_t       root_next [NSTEP+1][NCOMP];

  // Output register.
  logic                     out_v;
  logic signed [COMP_W-1:0] out_c [NCOMP];

  assign cfg.ready    = 1'b1;
  assign adv          = !out_v || normals.ready;
  assign texels.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      green_up <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      green_up <= cfg.green_up;
    end
  end

  // x and y are |code-128| clamped to 127; z is |2*blue-255|, always odd.
  always_comb begin
    red   = texels.texel[23:16];
    green = texels.texel[15:8];
    blue  = texels.texel[7:0];
    if (red[7]) begin
      xm = red[6:0];
    end else if (red == 8'd0) begin
      xm = 7'd127;
    end else begin
      xm = 7'(8'd128 - red);
    end
    if (green[7]) begin
      ym = green[6:0];
    end else if (green == 8'd0) begin
      ym = 7'd127;
    end else begin
      ym = 7'(8'd128 - green);
    end
    zm = {(blue[7] ? blue[6:0] : ~blue[6:0]), 1'b1};
    mag_in[COMP_X] = MAG_W'({xm, 8'd0}) - MAG_W'(xm);
    mag_in[COMP_Y] = MAG_W'({ym, 8'd0}) - MAG_W'(ym);
    mag_in[COMP_Z] = MAG_W'({zm, 7'd0}) - MAG_W'(zm);
    neg_in[COMP_X] = !red[7];
    neg_in[COMP_Y] = !green[7] ^ green_up;
    neg_in[COMP_Z] = !blue[7];
  end

  // Start state: n = 0, so m = 2n-1 = -1, rem = target - S and prod = m*S = -S.
  for (genvar c = 0; c < NCOMP; c++) begin : g_start
    assign root_next[0][c].rem  = REM_W'({sum_sq[c], {TGT_SHIFT{1'b0}}}) - REM_W'(sum_s);
    assign root_next[0][c].prod = PROD_W'(0) - PROD_W'(sum_s);
    assign root_next[0][c].n    = '0;
  end

  // Digit j tries n + 2^k. With m' = m + 2^(k+1), the remainder drops by
  // 2^(k+2)*m*S + 2^(2k+2)*S, and the digit is kept when it stays non-negative.
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int K = NSTEP - 1 - j;
    for (genvar c = 0; c < NCOMP; c++) begin : g_comp
      logic signed [WORK_W-1:0] try_rem;
      logic                     keep;

      assign try_rem = WORK_W'($signed(root[j][c].rem))
                     - (WORK_W'($signed(root[j][c].prod)) << (K + 2))
                     - (WORK_W'(pipe_s[j]) << (2 * K + 2));
      assign keep = !try_rem[WORK_W-1];

      assign root_next[j+1][c].rem  = keep ? try_rem[REM_W-1:0] : root[j][c].rem;
      assign root_next[j+1][c].prod = keep
          ? root[j][c].prod + (PROD_W'(pipe_s[j]) << (K + 1))
          : root[j][c].prod;
      assign root_next[j+1][c].n    = keep ? (root[j][c].n | (N_W'(1) << K))
                                           : root[j][c].n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_v  <= 1'b0;
      sq_v   <= 1'b0;
      sum_v  <= 1'b0;
      pipe_v <= '0;
      out_v  <= 1'b0;
    end else if (adv) begin
      dec_v  <= texels.valid;
      sq_v   <= dec_v;
      sum_v  <= sq_v;
      pipe_v <= {pipe_v[NSTEP-1:0], sum_v};
      out_v  <= pipe_v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_mag <= mag_in;
      dec_neg <= neg_in;
      for (int c = 0; c < NCOMP; c++) begin
        sq_val[c] <= SQ_W'(dec_mag[c]) * SQ_W'(dec_mag[c]);
      end
      sq_neg  <= dec_neg;
      sum_sq  <= sq_val;
      sum_neg <= sq_neg;
      sum_s   <= SUM_W'(sq_val[COMP_X]) + SUM_W'(sq_val[COMP_Y]) + SUM_W'(sq_val[COMP_Z]);
      pipe_s[0]   <= sum_s;
      pipe_neg[0] <= sum_neg;
      for (int j = 0; j < NSTEP; j++) begin
        pipe_s[j+1]   <= pipe_s[j];
        pipe_neg[j+1] <= pipe_neg[j];
      end
      for (int j = 0; j <= NSTEP; j++) begin
        for (int c = 0; c < NCOMP; c++) begin
          root[j][c] <= root_next[j][c];
        end
      end
      for (int c = 0; c < NCOMP; c++) begin
        out_c[c] <= pipe_neg[NSTEP][c] ? (COMP_W'(0) - COMP_W'(root[NSTEP][c].n))
                                       : COMP_W'(root[NSTEP][c].n);
      end
    end
  end

  assign normals.valid    = out_v;
  assign normals.normal_x = out_c[COMP_X];
  assign normals.normal_y = out_c[COMP_Y];
  assign normals.normal_z = out_c[COMP_Z];

  // A kept digit always leaves a non-negative remainder; checked here for z after the last digit.
  a_rem_nonneg: assert property (@(posedge clk) disable iff (rst)
    pipe_v[NSTEP] && (root[NSTEP][COMP_Z].n != '0) |-> !root[NSTEP][COMP_Z].rem[REM_W-1])
    else $error("negative remainder after the last digit");

  // |z| is at least 1/255 of the largest component, so z never rounds to zero.
  a_z_nonzero: assert property (@(posedge clk) disable iff (rst)
    normals.valid |-> (normals.normal_z != '0))
    else $error("z component rounded to zero");

  // No component exceeds one in magnitude; checked here for x.
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    normals.valid |-> (normals.normal_x <= 16'sd16384) && (normals.normal_x >= -16'sd16384))
    else $error("x component out of range");

endmodule

[tb/sv/tb_normal_map_texel_decode.sv]
`timescale 1ns / 100ps

module tb_normal_map_texel_decode;
  import nmtd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;

  typedef struct packed {
    logic [TEXEL_W-1:0]       texel;
    logic signed [COMP_W-1:0] nx;
    logic signed [COMP_W-1:0] ny;
    logic signed [COMP_W-1:0] nz;
  } normal_exp_t;

  class normal_checker;
    normal_exp_t pending_normals[$];
    bit          green_up;
    int          mismatches;

    function new();
      green_up   = 1'b0;
      mismatches = 0;
    endfunction

    // Rounded Q1.14 magnitude: the largest n in [0,16384] with
    // (2n-1)^2 * sum <= (32768*mag)^2, which rounds ties away from zero.
    function automatic int unsigned round_mag(longint unsigned mag, longint unsigned sum);
      longint unsigned target;
      longint unsigned odd;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     mid;
      target = (64'd32768 * mag) * (64'd32768 * mag);
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        odd = 64'(mid) * 2 - 1;
        if (odd * odd * sum <= target) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function automatic logic signed [COMP_W-1:0] scale_comp(longint c, longint unsigned sum);
      int unsigned n;
      n = round_mag(longint'(c < 0 ? -c : c), sum);
      return (c < 0) ? -COMP_W'(n) : COMP_W'(n);
    endfunction

    function automatic normal_exp_t decode_normal(logic [TEXEL_W-1:0] t);
      normal_exp_t     e;
      longint          r;
      longint          g;
      longint          b;
      longint          xc;
      longint          yc;
      longint          zc;
      longint unsigned sum;
      r = longint'(t[23:16]) - 128;
      g = longint'(t[15:8]) - 128;
      b = longint'(t[7:0]);
      // A code of 0 decodes just below -1 and is clamped.
      if (r < -127) r = -127;
      if (g < -127) g = -127;
      if (green_up) g = -g;
      xc  = r * 255;
      yc  = g * 255;
      zc  = (2 * b - 255) * 127;
      sum = longint'(xc * xc + yc * yc + zc * zc);
      e.texel = t;
      if (sum == 0) begin
        e.nx = '0;
        e.ny = '0;
        e.nz = 16'sd16384;
      end else begin
        e.nx = scale_comp(xc, sum);
        e.ny = scale_comp(yc, sum);
        e.nz = scale_comp(zc, sum);
      end
      return e;
    endfunction

    function void note_texel(logic [TEXEL_W-1:0] t);
      pending_normals = {pending_normals, decode_normal(t)};
    endfunction

    function void check_normal(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                               logic signed [COMP_W-1:0] z);
      normal_exp_t e;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected normal (%0d, %0d, %0d) with no texel outstanding", x, y, z);
        return;
      end
      e = pending_normals.pop_front();
      if (x !== e.nx || y !== e.ny || z !== e.nz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Texel %06h: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                   e.texel, e.nx, e.ny, e.nz, x, y, z);
      end
    endfunction

    function bit drained();
      return pending_normals.size() == 0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  nmtd_cfg_if    cfg_bus ();
  nmtd_texel_if  texel_bus ();
  nmtd_normal_if normal_bus ();

  normal_map_texel_decode i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .texels  (texel_bus),
    .normals (normal_bus)
  );

  normal_checker checker_h = new();
  bit            tx_calm;
  bit            rx_calm;
  int            idle_cycles;

  always #5 clk = ~clk;

  initial begin
    cfg_bus.valid    = 1'b0;
    cfg_bus.green_up = 1'b0;
    texel_bus.valid  = 1'b0;
    texel_bus.texel  = '0;
    normal_bus.ready = 1'b0;
  end

  // Monitors: every accepted texel is predicted, every accepted normal checked.
  always @(posedge clk) begin
    if (!rst && texel_bus.valid && texel_bus.ready)
      checker_h.note_texel(texel_bus.texel);
    if (!rst && normal_bus.valid && normal_bus.ready)
      checker_h.check_normal(normal_bus.normal_x, normal_bus.normal_y, normal_bus.normal_z);
  end

  always @(posedge clk) begin
    if (rst || (texel_bus.valid && texel_bus.ready) || (normal_bus.valid && normal_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: holds ready low for a drawn number of cycles before each transfer.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        normal_bus.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      normal_bus.ready = 1'b1;
      do @(posedge clk); while (!(normal_bus.valid && !rst));
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so a back-to-back texel can follow directly.
  task automatic send_texel(logic [TEXEL_W-1:0] t);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      texel_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    texel_bus.valid = 1'b1;
    texel_bus.texel = t;
    do @(posedge clk); while (!texel_bus.ready);
    @(negedge clk);
  endtask

  task automatic drain_normals();
    texel_bus.valid = 1'b0;
    while (!checker_h.drained()) @(negedge clk);
  endtask

  task automatic write_green_up(bit v);
    drain_normals();
    repeat (25) @(negedge clk);
    cfg_bus.valid    = 1'b1;
    cfg_bus.green_up = v;
    do @(posedge clk); while (!cfg_bus.ready);
    checker_h.green_up = v;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_code();
    logic [7:0] codes[7] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return codes[sel];
    return 8'($urandom);
  endfunction

  function automatic logic [TEXEL_W-1:0] pick_texel();
    if ($urandom_range(0, 9) < 7) return TEXEL_W'($urandom);
    return {pick_code(), pick_code(), pick_code()};
  endfunction

  logic [TEXEL_W-1:0] corner_texels[13] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h8080FF, 24'h808000,
    24'h808001, 24'h8080FE, 24'hFF8080, 24'h008080, 24'h018080,
    24'h800080, 24'h80FF80, 24'h00FF7F
  };

  initial begin
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Corner codes under the reset setting, then with the green channel flipped.
    foreach (corner_texels[i]) send_texel(corner_texels[i]);
    write_green_up(1'b1);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    foreach (corner_texels[i]) send_texel(corner_texels[i]);

    for (int p = 0; p < PHASES; p++) begin
      write_green_up((p % 3) == 1 ? 1'b1 : 1'b0 ^ p[0]);
      tx_calm = (p == 0) || (p == 5);
      rx_calm = (p == 0) || (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the stream until the pipeline has emptied once mid-phase.
        if (p == 2 && i == PHASE_ITEMS / 2) drain_normals();
        send_texel(pick_texel());
      end
    end

    drain_normals();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (checker_h.mismatches == 0 && checker_h.drained()) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
